// ===== hw/rtl/dle_rx_pkg.sv =====
package dle_rx_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);

  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

  localparam logic [BYTE_W-1:0] START_RST  = 8'h02;
  localparam logic [BYTE_W-1:0] END_RST    = 8'h03;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h10;

  // controller to datapath
  typedef struct packed {
    logic take;      // input transfer this cycle
    logic rd_first;  // read the first stored byte
    logic load;      // move read data into the output register
    logic rd_next;   // read the following stored byte
  } dle_rx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close_emit;  // current input byte closes a frame worth sending
    logic rd_last;     // byte being read is the last of the frame
    logic out_free;    // output register can take a byte
  } dle_rx_sts_t;

endpackage

// ===== hw/rtl/dle_escaped_frame_receiver_unit.sv =====
// Deframer for STX ... ETX link traffic with DLE escaping.
// Input channel: one raw link byte per transfer on in_rx_byte (in_valid/in_ready).
// Output channel: payload bytes of each completed frame, in order, with
// out_last_byte on the final byte and out_truncated on every byte of a frame
// that overflowed the 64-byte store (out_valid/out_ready).
// Config port: cfg_we, cfg_index (0 start, 1 end, 2 escape), cfg_wdata;
// write only while the block is idle.
// After the closing byte of a frame of n >= 2 bytes, in_ready stays low while
// the frame is read back from the store, one byte per cycle while out_ready is
// high, through its single read port: the first byte passes the store's read
// register and then the output register, and the input reopens once the last
// byte is in the output register.
// A stalled out_ready holds the output register and the read-back in place.
// Frames closing with fewer than two bytes give no output.
// Reset: start 0x02, end 0x03, escape 0x10, no frame open, output empty;
// the store is not cleared, only bytes of the current frame are read.
module dle_escaped_frame_receiver_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dle_rx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dle_rx_pkg::BYTE_W-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dle_rx_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dle_rx_pkg::BYTE_W-1:0]     out_frame_byte,
  output logic                              out_last_byte,
  output logic                              out_truncated
);
  import dle_rx_pkg::*;

  dle_rx_cmd_t cmd;
  dle_rx_sts_t sts;

  dle_rx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dle_rx_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_rx_byte     (in_rx_byte),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_truncated  (out_truncated),
    .cmd            (cmd),
    .sts            (sts)
  );

`ifndef SYNTHESIS
  // a frame read-back blocks the input until its last byte is loaded
  a_close_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_first |=> !in_ready)
    else $error("input not blocked after frame close");

  a_last_reopens_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.rd_last) |=> in_ready)
    else $error("input not reopened after last byte");

  a_load_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (out_valid && (out_last_byte == $past(sts.rd_last))))
    else $error("output register not loaded");

  a_no_load_while_taking: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take && (cmd.load || cmd.rd_next)))
    else $error("input transfer during frame read-back");
`endif

endmodule

// ===== hw/rtl/dle_rx_ram.sv =====
module dle_rx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dle_rx_ctrl.sv =====
module dle_rx_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  dle_rx_pkg::dle_rx_sts_t sts,
  output dle_rx_pkg::dle_rx_cmd_t cmd
);
  import dle_rx_pkg::*;

  localparam logic [0:0] ST_IDLE  = 1'b0;
  localparam logic [0:0] ST_DRAIN = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.take     = in_valid;
        if (in_valid && sts.close_emit) begin
          cmd.rd_first = 1'b1;
          state_nxt    = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.rd_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/dle_rx_dp.sv =====
module dle_rx_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dle_rx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dle_rx_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic [dle_rx_pkg::BYTE_W-1:0]       in_rx_byte,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [dle_rx_pkg::BYTE_W-1:0]       out_frame_byte,
  output logic                                out_last_byte,
  output logic                                out_truncated,
  input  dle_rx_pkg::dle_rx_cmd_t             cmd,
  output dle_rx_pkg::dle_rx_sts_t             sts
);
  import dle_rx_pkg::*;

  logic [BYTE_W-1:0] start_r, end_r, escape_r;
  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_trunc_r;

  logic              is_open, is_close, is_esc, has_room;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // byte classification, in priority order start, end, escape
  assign is_open  = !in_frame_r && (in_rx_byte == start_r) && !esc_r;
  assign is_close = in_frame_r && (in_rx_byte == end_r) && !esc_r;
  assign is_esc   = !is_open && !is_close && (in_rx_byte == escape_r) && !esc_r;
  assign has_room = len_r < LEN_W'(MAX_FRAME_BYTES);

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    ovf_nxt      = ovf_r;
    len_nxt      = len_r;
    wr_en        = 1'b0;
    if (cmd.take) begin
      priority if (is_open) begin
        in_frame_nxt = 1'b1;
        len_nxt      = '0;
        ovf_nxt      = 1'b0;
      end else if (is_close) begin
        in_frame_nxt = 1'b0;
      end else if (is_esc) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (in_frame_r) begin
          if (has_room) begin
            wr_en   = 1'b1;
            len_nxt = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign rd_en   = cmd.rd_first || cmd.rd_next;
  assign rd_addr = cmd.rd_first ? '0 : rd_idx_r + ADDR_W'(1);

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (rd_en) begin
      rd_idx_nxt = rd_addr;
    end
  end

  always_comb begin
    sts.close_emit = is_close && (len_r >= LEN_W'(2));
    sts.rd_last    = ({1'b0, rd_idx_r} == LEN_W'(len_r - LEN_W'(1)));
    sts.out_free   = !out_valid_r || out_ready;
  end

  dle_rx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (in_rx_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= START_RST;
      end_r       <= END_RST;
      escape_r    <= ESCAPE_RST;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      ovf_r       <= 1'b0;
      len_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START:  start_r  <= cfg_wdata;
          CFG_END:    end_r    <= cfg_wdata;
          CFG_ESCAPE: escape_r <= cfg_wdata;
          default: ;
        endcase
      end
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      ovf_r      <= ovf_nxt;
      len_r      <= len_nxt;
      rd_idx_r   <= rd_idx_nxt;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r  <= rd_data;
      out_last_r  <= sts.rd_last;
      out_trunc_r <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;
  assign out_truncated  = out_trunc_r;

endmodule

// ===== tb/sv/dle_escaped_frame_receiver_unit_test.sv =====
`timescale 1ns / 1ps

module dle_escaped_frame_receiver_unit_test;
  import dle_rx_pkg::*;

  localparam realtime CLK_PERIOD  = 12.0;
  localparam int      RESET_CYCLES = 12;
  localparam int      CYCLE_LIMIT  = 400000;
  localparam int      SETTLE_CYCLES = 8;
  localparam int      MSG_CAP      = 50;

  typedef logic [BYTE_W-1:0] link_byte_t;

  typedef struct packed {
    link_byte_t data;
    logic       last;
    logic       trunc;
  } payload_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START;
  link_byte_t           cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  link_byte_t           in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  link_byte_t           out_frame_byte;
  logic                 out_last_byte;
  logic                 out_truncated;

  // deframer state as the testbench sees it
  link_byte_t    sof_code = START_RST;
  link_byte_t    eof_code = END_RST;
  link_byte_t    esc_code = ESCAPE_RST;
  logic          rx_open = 1'b0;
  logic          esc_armed = 1'b0;
  link_byte_t    payload_buf [MAX_FRAME_BYTES];
  int            payload_len = 0;
  logic          payload_clipped = 1'b0;
  payload_beat_t expected_beats [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int fail_count = 0;
  int beats_checked = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int cycle_count = 0;
  payload_beat_t want;

  dle_escaped_frame_receiver_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_frame_byte(out_frame_byte),
    .out_last_byte (out_last_byte),
    .out_truncated (out_truncated)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still expected", $time, expected_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // unstuff one link byte and queue any frame bytes it releases
  function automatic void deframe_byte(input link_byte_t b);
    payload_beat_t beat;
    int i;
    if (!rx_open) begin
      if (b == sof_code && !esc_armed) begin
        rx_open = 1'b1;
        payload_len = 0;
        payload_clipped = 1'b0;
        return;
      end
    end else if (b == eof_code && !esc_armed) begin
      if (payload_len >= 2) begin
        for (i = 0; i < payload_len; i++) begin
          beat.data = payload_buf[i];
          beat.last = (i == payload_len - 1);
          beat.trunc = payload_clipped;
          expected_beats.insert(expected_beats.size(), beat);
        end
      end
      rx_open = 1'b0;
      return;
    end
    if (b == esc_code && !esc_armed) begin
      esc_armed = 1'b1;
      return;
    end
    esc_armed = 1'b0;
    if (rx_open) begin
      if (payload_len < MAX_FRAME_BYTES) begin
        payload_buf[payload_len] = b;
        payload_len++;
      end else begin
        payload_clipped = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= MSG_CAP)
          $display("%0t: unexpected byte: expected none, actual %h last %b trunc %b",
                   $time, out_frame_byte, out_last_byte, out_truncated);
      end else begin
        want = expected_beats.pop_front();
        if (out_frame_byte !== want.data) begin
          fail_count++;
          if (fail_count <= MSG_CAP)
            $display("%0t: frame_byte expected %h actual %h", $time, want.data, out_frame_byte);
        end
        if (out_last_byte !== want.last) begin
          fail_count++;
          if (fail_count <= MSG_CAP)
            $display("%0t: last_byte expected %b actual %b", $time, want.last, out_last_byte);
        end
        if (out_truncated !== want.trunc) begin
          fail_count++;
          if (fail_count <= MSG_CAP)
            $display("%0t: truncated expected %b actual %b", $time, want.trunc, out_truncated);
        end
      end
    end
  end

  // one transfer on the link side, with a random gap ahead of it
  task automatic push_link_byte(input link_byte_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    deframe_byte(b);
    bytes_sent++;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle_link();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_codes(input link_byte_t s, input link_byte_t e, input link_byte_t x);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= CFG_END;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_index <= CFG_ESCAPE;
    cfg_wdata <= x;
    @(posedge clk);
    cfg_we <= 1'b0;
    sof_code = s;
    eof_code = e;
    esc_code = x;
  endtask

  // code values turn up often so that stuffing gets exercised
  function automatic link_byte_t pick_byte();
    case ($urandom_range(9))
      0: return sof_code;
      1: return eof_code;
      2: return esc_code;
      default: return link_byte_t'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input int len);
    link_byte_t b;
    int k;
    push_link_byte(sof_code);
    for (k = 0; k < len; k++) begin
      b = pick_byte();
      if (b == eof_code || b == esc_code)
        push_link_byte(esc_code);
      push_link_byte(b);
    end
    push_link_byte(eof_code);
    frames_sent++;
  endtask

  // mostly well-formed frames, some stray bytes and broken sequences
  task automatic run_random_traffic(input int n_bytes);
    int stop_at;
    int k;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        send_frame($urandom_range(6));
      end else begin
        for (k = $urandom_range(4, 1); k > 0; k--)
          push_link_byte(pick_byte());
      end
    end
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    // smallest frame with extreme data
    push_link_byte(8'h02); push_link_byte(8'h00); push_link_byte(8'hFF); push_link_byte(8'h03);
    // empty and single byte frames are dropped
    push_link_byte(8'h02); push_link_byte(8'h03);
    push_link_byte(8'h02); push_link_byte(8'h55); push_link_byte(8'h03);
    // escaped start outside a frame opens nothing
    push_link_byte(8'h10); push_link_byte(8'h02); push_link_byte(8'h41); push_link_byte(8'h03);
    // start byte as data, escaped end and escaped escape
    push_link_byte(8'h02); push_link_byte(8'h02); push_link_byte(8'h10); push_link_byte(8'h03);
    push_link_byte(8'h10); push_link_byte(8'h10); push_link_byte(8'hAA); push_link_byte(8'h03);
    settle_link();
  endtask

  task automatic test_reset_codes();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_random_traffic(5);
    settle_link();
  endtask

  task automatic test_extreme_codes();
    set_codes(8'h00, 8'hFF, 8'h80);
    src_idle_pct = 85;
    sink_stall_pct = 0;
    run_random_traffic(5);
    settle_link();
    set_codes(8'hFF, 8'h00, 8'h7F);
    src_idle_pct = 0;
    sink_stall_pct = 85;
    run_random_traffic(5);
    settle_link();
  endtask

  task automatic test_code_clash();
    src_idle_pct = 11;
    sink_stall_pct = 11;
    set_codes(8'h5A, 8'h5A, 8'h5A);
    run_random_traffic(5);
    settle_link();
    set_codes(8'h01, 8'h81, 8'h81);
    run_random_traffic(5);
    settle_link();
  endtask

  task automatic test_store_limit();
    int n;
    int k;
    set_codes(START_RST, END_RST, ESCAPE_RST);
    src_idle_pct = 11;
    sink_stall_pct = 85;
    // close or flush whatever the earlier traffic left open
    push_link_byte(eof_code);
    push_link_byte(eof_code);
    // plain data past the end of the store, no stuffing needed
    n = MAX_FRAME_BYTES + $urandom_range(3, 1);
    push_link_byte(sof_code);
    for (k = 0; k < n; k++)
      push_link_byte(link_byte_t'(8'h20 + k));
    push_link_byte(eof_code);
    frames_sent++;
    // overflow mark must clear on the next frame
    send_frame(2);
    settle_link();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_reset_codes();
    test_extreme_codes();
    test_code_clash();
    test_store_limit();
    $display("covered %0d link bytes in %0d generated frames over five code settings,",
             bytes_sent, frames_sent);
    $display("with %0d frame bytes checked under mixed link gaps and output stalls",
             beats_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dle_rx_pkg.sv
hw/rtl/dle_rx_ram.sv
hw/rtl/dle_rx_ctrl.sv
hw/rtl/dle_rx_dp.sv
hw/rtl/dle_escaped_frame_receiver_unit.sv
tb/sv/dle_escaped_frame_receiver_unit_test.sv
